/* design/dvtu_pkg.sv */
`timescale 1ns / 1ps

package dvtu_pkg;

	// Table geometry
	localparam int NODE_COUNT  = 4;
	localparam int NODE_W      = 2;
	localparam int IDX_W       = 2 * NODE_W;
	localparam int TABLE_DEPTH = NODE_COUNT * NODE_COUNT;
	localparam int COST_W      = 16;
	localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
	localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);

	// Stream widths
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 3;

	// Item kinds
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_WRONG_DEST = 2'd1,
		ST_FROM_SELF  = 2'd2
	} status_t;

	// Program counter and entry points
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_LOAD     = 4'd0;
	localparam logic [PC_W-1:0] PC_ROW      = 4'd1;
	localparam logic [PC_W-1:0] PC_RELAX    = 4'd3;
	localparam logic [PC_W-1:0] PC_RELAX_J  = 4'd5;
	localparam logic [PC_W-1:0] PC_SYM      = 4'd8;
	localparam logic [PC_W-1:0] PC_OUT      = 4'd11;
	localparam logic [PC_W-1:0] PC_SYM_WR   = 4'd14;

	// Table read selection (read data is registered)
	typedef enum logic [2:0] {
		RD_NONE,
		RD_ROW,
		RD_OWN,
		RD_RELAX,
		RD_SYM
	} rd_t;

	// Datapath action
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD_WR,
		DP_ROW_CMP,
		DP_ACC_LD,
		DP_RELAX,
		DP_ACC_WR,
		DP_SYM_CMP,
		DP_SYM_WR1,
		DP_SYM_WR2,
		DP_OUT_CAP
	} dp_op_t;

	// Row/column counter action
	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_INC_J,
		CNT_INC_I,
		CNT_INC_IJ,
		CNT_CLR
	} cnt_t;

	// Jump condition
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_J_MORE,
		JC_I_MORE,
		JC_DIFF,
		JC_PAIR_MORE
	} jc_t;

	typedef struct packed {
		rd_t              rd;
		dp_op_t           op;
		cnt_t             cnt;
		jc_t              jc;
		logic [PC_W-1:0]  target;
		logic             fin;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		rd_t               rd;
		dp_op_t            op;
		logic [NODE_W-1:0] i;
		logic [NODE_W-1:0] j;
	} ctl_t;

	// Captured input item
	typedef struct packed {
		logic [NODE_W-1:0]                  src;
		logic [NODE_COUNT-1:0][COST_W-1:0]  cost;
		logic [NODE_W-1:0]                  row;
		logic [NODE_W-1:0]                  col;
		logic [COST_W-1:0]                  value;
	} item_t;

	// Control store
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		w.rd     = RD_NONE;
		w.op     = DP_NOP;
		w.cnt    = CNT_HOLD;
		w.jc     = JC_NEXT;
		w.target = '0;
		w.fin    = 1'b0;
		case (pc)
			// load: write one entry, then report
			4'd0: begin
				w.op = DP_LOAD_WR; w.jc = JC_ALWAYS; w.target = PC_OUT;
			end
			// merge advertised costs into the source row
			4'd1: begin
				w.rd = RD_ROW;
			end
			4'd2: begin
				w.op = DP_ROW_CMP; w.cnt = CNT_INC_J;
				w.jc = JC_J_MORE; w.target = PC_ROW;
			end
			// relax own column, one row at a time
			4'd3: begin
				w.rd = RD_OWN;
			end
			4'd4: begin
				w.op = DP_ACC_LD;
			end
			4'd5: begin
				w.rd = RD_RELAX;
			end
			4'd6: begin
				w.op = DP_RELAX; w.cnt = CNT_INC_J;
				w.jc = JC_J_MORE; w.target = PC_RELAX_J;
			end
			4'd7: begin
				w.op = DP_ACC_WR; w.cnt = CNT_INC_I;
				w.jc = JC_I_MORE; w.target = PC_RELAX;
			end
			// find first asymmetric pair
			4'd8: begin
				w.rd = RD_SYM;
			end
			4'd9: begin
				w.op = DP_SYM_CMP; w.jc = JC_DIFF; w.target = PC_SYM_WR;
			end
			// after the last pair the counters are back at zero: fall into read-out
			4'd10: begin
				w.cnt = CNT_INC_IJ; w.jc = JC_PAIR_MORE; w.target = PC_SYM;
			end
			// read out own column
			4'd11: begin
				w.rd = RD_OWN;
			end
			4'd12: begin
				w.op = DP_OUT_CAP; w.cnt = CNT_INC_I;
				w.jc = JC_I_MORE; w.target = PC_OUT;
			end
			4'd13: begin
				w.fin = 1'b1;
			end
			// settle the asymmetric pair, then report
			4'd14: begin
				w.op = DP_SYM_WR1;
			end
			4'd15: begin
				w.op = DP_SYM_WR2; w.cnt = CNT_CLR;
				w.jc = JC_ALWAYS; w.target = PC_OUT;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

/* design/dvtu_seq.sv */
`timescale 1ns / 1ps

module dvtu_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dvtu_pkg::PC_W-1:0]    entry,
	input  logic                         out_busy,
	input  logic                         diff,
	output dvtu_pkg::ctl_t               ctl,
	output logic                         busy,
	output logic                         done
);

	logic                          busy_q;
	logic [dvtu_pkg::PC_W-1:0]     pc_q;
	logic [dvtu_pkg::NODE_W-1:0]   i_q;
	logic [dvtu_pkg::NODE_W-1:0]   j_q;
	logic [dvtu_pkg::NODE_W-1:0]   i_d;
	logic [dvtu_pkg::NODE_W-1:0]   j_d;
	logic [dvtu_pkg::NODE_W-1:0]   i_inc;
	logic [dvtu_pkg::NODE_W-1:0]   j_inc;
	logic                          i_last;
	logic                          j_last;
	logic                          taken;
	logic                          stall;
	dvtu_pkg::ucode_t              w;

	// Decode current control word
	always_comb begin
		w      = dvtu_pkg::ucode(pc_q);
		i_last = (i_q == dvtu_pkg::NODE_LAST);
		j_last = (j_q == dvtu_pkg::NODE_LAST);
		i_inc  = i_last ? '0 : i_q + 1'b1;
		j_inc  = j_last ? '0 : j_q + 1'b1;

		case (w.jc)
			dvtu_pkg::JC_NEXT:      taken = 1'b0;
			dvtu_pkg::JC_ALWAYS:    taken = 1'b1;
			dvtu_pkg::JC_J_MORE:    taken = !j_last;
			dvtu_pkg::JC_I_MORE:    taken = !i_last;
			dvtu_pkg::JC_DIFF:      taken = diff;
			dvtu_pkg::JC_PAIR_MORE: taken = !(i_last && j_last);
			default:                taken = 1'b0;
		endcase

		i_d = i_q;
		j_d = j_q;
		case (w.cnt)
			dvtu_pkg::CNT_HOLD: begin
			end
			dvtu_pkg::CNT_INC_J: begin
				j_d = j_inc;
			end
			dvtu_pkg::CNT_INC_I: begin
				i_d = i_inc;
			end
			dvtu_pkg::CNT_INC_IJ: begin
				j_d = j_inc;
				if (j_last) begin
					i_d = i_inc;
				end
			end
			dvtu_pkg::CNT_CLR: begin
				i_d = '0;
				j_d = '0;
			end
			default: begin
			end
		endcase

		stall  = w.fin && out_busy;
		done   = busy_q && w.fin && !out_busy;
		busy   = busy_q;
		ctl.rd = busy_q ? w.rd : dvtu_pkg::RD_NONE;
		ctl.op = busy_q ? w.op : dvtu_pkg::DP_NOP;
		ctl.i  = i_q;
		ctl.j  = j_q;
	end

	// Step counter and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
			i_q    <= '0;
			j_q    <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (!stall) begin
				pc_q <= taken ? w.target : pc_q + 1'b1;
				i_q  <= i_d;
				j_q  <= j_d;
			end
		end
	end

	// A new item never lands on a running program
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("start while sequencer busy");

endmodule

/* design/dvtu_dp.sv */
`timescale 1ns / 1ps

module dvtu_dp (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               start,
	input  dvtu_pkg::ctl_t                                     ctl,
	input  dvtu_pkg::item_t                                    item,
	input  logic [dvtu_pkg::NODE_W-1:0]                        own_node,
	output logic                                               diff,
	output logic                                               changed,
	output logic [dvtu_pkg::NODE_COUNT-1:0][dvtu_pkg::COST_W-1:0] own_col
);

	logic [dvtu_pkg::COST_W-1:0]      mem [dvtu_pkg::TABLE_DEPTH];
	logic [dvtu_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [dvtu_pkg::COST_W-1:0]      rda_q;
	logic [dvtu_pkg::COST_W-1:0]      rdb_q;
	logic [dvtu_pkg::COST_W-1:0]      acc_q;
	logic [dvtu_pkg::COST_W-1:0]      min_q;
	logic                             changed_q;
	logic [dvtu_pkg::NODE_COUNT-1:0][dvtu_pkg::COST_W-1:0] own_col_q;

	logic [dvtu_pkg::IDX_W-1:0]       ra;
	logic [dvtu_pkg::IDX_W-1:0]       rb;
	logic [dvtu_pkg::IDX_W-1:0]       wa;
	logic [dvtu_pkg::COST_W-1:0]      wd;
	logic                             we;
	logic [dvtu_pkg::COST_W-1:0]      cost_j;
	logic [dvtu_pkg::COST_W-1:0]      a_eff;
	logic [dvtu_pkg::COST_W-1:0]      b_eff;
	logic [dvtu_pkg::COST_W:0]        sum;
	logic [dvtu_pkg::COST_W-1:0]      cand;

	// Read address selection
	always_comb begin
		ra = '0;
		rb = '0;
		case (ctl.rd)
			dvtu_pkg::RD_NONE: begin
			end
			dvtu_pkg::RD_ROW: begin
				ra = {item.src, ctl.j};
			end
			dvtu_pkg::RD_OWN: begin
				ra = {ctl.i, own_node};
			end
			dvtu_pkg::RD_RELAX: begin
				ra = {ctl.i, ctl.j};
				rb = {ctl.j, own_node};
			end
			dvtu_pkg::RD_SYM: begin
				ra = {ctl.i, ctl.j};
				rb = {ctl.j, ctl.i};
			end
			default: begin
			end
		endcase
	end

	// Relaxation: the own-column entry of row i lives in acc_q until written back
	always_comb begin
		cost_j = item.cost[ctl.j];
		a_eff  = (ctl.j == own_node) ? acc_q : rda_q;
		b_eff  = (ctl.j == ctl.i) ? acc_q : rdb_q;
		sum    = {1'b0, a_eff} + {1'b0, b_eff};
		cand   = sum[dvtu_pkg::COST_W] ? dvtu_pkg::COST_MAX : sum[dvtu_pkg::COST_W-1:0];
		diff   = (rda_q != rdb_q);
	end

	// Write port selection
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		case (ctl.op)
			dvtu_pkg::DP_LOAD_WR: begin
				we = 1'b1;
				wa = {item.row, item.col};
				wd = item.value;
			end
			dvtu_pkg::DP_ROW_CMP: begin
				we = (cost_j < rda_q);
				wa = {item.src, ctl.j};
				wd = cost_j;
			end
			dvtu_pkg::DP_ACC_WR: begin
				we = 1'b1;
				wa = {ctl.i, own_node};
				wd = acc_q;
			end
			dvtu_pkg::DP_SYM_WR1: begin
				we = 1'b1;
				wa = {ctl.i, ctl.j};
				wd = min_q;
			end
			dvtu_pkg::DP_SYM_WR2: begin
				we = 1'b1;
				wa = {ctl.j, ctl.i};
				wd = min_q;
			end
			default: begin
			end
		endcase
	end

	// Cost table: one write, two registered reads; unwritten entries read unreachable
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rda_q <= valid_q[ra] ? mem[ra] : dvtu_pkg::COST_MAX;
		rdb_q <= valid_q[rb] ? mem[rb] : dvtu_pkg::COST_MAX;
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wa] <= 1'b1;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			dvtu_pkg::DP_ACC_LD: begin
				acc_q <= rda_q;
			end
			dvtu_pkg::DP_RELAX: begin
				if (cand < acc_q) begin
					acc_q <= cand;
				end
			end
			dvtu_pkg::DP_SYM_CMP: begin
				min_q <= (rda_q < rdb_q) ? rda_q : rdb_q;
			end
			dvtu_pkg::DP_OUT_CAP: begin
				own_col_q[ctl.i] <= rda_q;
			end
			default: begin
			end
		endcase
	end

	// Track whether the advertised row differs from the stored one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (start) begin
			changed_q <= 1'b0;
		end else if (ctl.op == dvtu_pkg::DP_ROW_CMP && cost_j != rda_q) begin
			changed_q <= 1'b1;
		end
	end

	assign changed = changed_q;
	assign own_col = own_col_q;

	// Relaxation never raises the running cost
	a_relax_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == dvtu_pkg::DP_RELAX |=> acc_q <= $past(acc_q))
		else $error("relaxation raised accumulated cost");

	// A differing advertised cost sets the change flag
	a_changed_set: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == dvtu_pkg::DP_ROW_CMP && cost_j != rda_q) |=> changed_q)
		else $error("change flag missed");

endmodule

/* design/distance_vector_table_update.sv */
`timescale 1ns / 1ps

// Channel  Dir  Signals                          Contents
// s_       in   s_tvalid s_tready s_tdata s_tuser  one load or routing packet item
// m_       out  m_tvalid m_tready m_tdata m_tuser  status, change flag, own cost column
// cfg_     in   cfg_valid cfg_ready cfg_data       own node identity
//
// One item at a time; the program starts the cycle after accept.
// A valid packet's program length is set by the single-write, two-read cost table
// port: two steps per relaxation and three per symmetry check, over all 16 (row,
// intermediate) and (row, column) pairs.
// Reset: the cost table reads unreachable everywhere and own node is 0.
// A held result stalls the program on its last step until it is taken.

module distance_vector_table_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// source_node[1:0] dest_node[3:2] cost_0[19:4] cost_1[35:20] cost_2[51:36]
	// cost_3[67:52] entry_row[69:68] entry_col[71:70] entry_value[87:72]
	input  logic [dvtu_pkg::IN_DATA_W-1:0]    s_tdata,
	// opcode[0]
	input  logic [dvtu_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// own_cost_0[15:0] own_cost_1[31:16] own_cost_2[47:32] own_cost_3[63:48]
	output logic [dvtu_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status[1:0] changed[2]
	output logic [dvtu_pkg::OUT_USER_W-1:0]   m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dvtu_pkg::NODE_W-1:0]       cfg_data
);

	logic [dvtu_pkg::NODE_W-1:0]      own_node_q;
	dvtu_pkg::item_t                  item_d;
	dvtu_pkg::item_t                  item_q;
	logic [dvtu_pkg::NODE_W-1:0]      dst;
	logic                             opcode;
	dvtu_pkg::status_t                status_d;
	dvtu_pkg::status_t                status_q;
	logic [dvtu_pkg::PC_W-1:0]        entry;
	logic                             s_accept;
	logic                             busy;
	logic                             done;
	logic                             diff;
	logic                             changed;
	logic                             out_busy;
	dvtu_pkg::ctl_t                   ctl;
	logic [dvtu_pkg::NODE_COUNT-1:0][dvtu_pkg::COST_W-1:0] own_col;
	logic                             m_tvalid_q;
	logic [dvtu_pkg::OUT_DATA_W-1:0]  m_tdata_q;
	logic [dvtu_pkg::OUT_USER_W-1:0]  m_tuser_q;

	// Unpack the input item
	always_comb begin
		opcode     = s_tuser[0];
		item_d.src = s_tdata[1:0];
		dst        = s_tdata[3:2];
		for (int r = 0; r < dvtu_pkg::NODE_COUNT; r++) begin
			item_d.cost[r] = s_tdata[4 + r*dvtu_pkg::COST_W +: dvtu_pkg::COST_W];
		end
		item_d.row   = s_tdata[69:68];
		item_d.col   = s_tdata[71:70];
		item_d.value = s_tdata[87:72];
	end

	// Pick the program entry and status
	always_comb begin
		if (opcode == dvtu_pkg::OP_LOAD) begin
			entry    = dvtu_pkg::PC_LOAD;
			status_d = dvtu_pkg::ST_OK;
		end else if (dst != own_node_q) begin
			entry    = dvtu_pkg::PC_OUT;
			status_d = dvtu_pkg::ST_WRONG_DEST;
		end else if (item_d.src == own_node_q) begin
			entry    = dvtu_pkg::PC_OUT;
			status_d = dvtu_pkg::ST_FROM_SELF;
		end else begin
			entry    = dvtu_pkg::PC_ROW;
			status_d = dvtu_pkg::ST_OK;
		end
	end

	assign s_tready  = !busy;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_busy  = m_tvalid_q && !m_tready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_node_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_node_q <= cfg_data;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_q   <= item_d;
			status_q <= status_d;
		end
	end

	dvtu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_accept),
		.entry    (entry),
		.out_busy (out_busy),
		.diff     (diff),
		.ctl      (ctl),
		.busy     (busy),
		.done     (done)
	);

	dvtu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_accept),
		.ctl      (ctl),
		.item     (item_q),
		.own_node (own_node_q),
		.diff     (diff),
		.changed  (changed),
		.own_col  (own_col)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= own_col;
			m_tuser_q <= {changed, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Accepted item starts the program
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> busy)
		else $error("accepted item did not start the program");

	// A finished item never overwrites a held result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten before taken");

endmodule
